>>> hw/rtl/ehash_pkg.sv
// ----------------------------------------------------------------------------
// ehash_pkg
// Shared types and codes of the extendible hash table: request and response
// payloads, stored record layout, action and status codes.
// ----------------------------------------------------------------------------
package ehash_pkg;

  // request actions
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_SEARCH = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // response status codes
  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_FOUND    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] key;
    logic [63:0] value;
    logic [3:0]  value_length;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] value_out;
    logic [3:0]  length_out;
  } rsp_t;

  // one stored record slot
  typedef struct packed {
    logic [63:0] key;
    logic [63:0] value;
    logic [3:0]  len;
  } rec_t;

  localparam int unsigned REC_W = $bits(rec_t);

endpackage

>>> hw/rtl/ehash_ram.sv
// ----------------------------------------------------------------------------
// ehash_ram
// Simple dual-port synchronous memory: one write port and one read port with a
// registered read.
// ----------------------------------------------------------------------------
module ehash_ram #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [W-1:0]             wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [W-1:0]             rdata_o
);

  logic [W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> hw/rtl/extendible_hash_table.sv
// ----------------------------------------------------------------------------
// extendible_hash_table
// Extendible hash table with fixed-slot buckets, directory doubling and
// bucket splits. Directory, bucket info and records live in three memories.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------
//  in      | input     | in_valid_i / in_ready_o | in_data_i (req_t)
//  out     | output    | out_valid_o/out_ready_i | out_data_o (rsp_t)
//  cfg     | input     | cfg_we_i                | cfg_wdata_i (capacity)
//
//  search/remove read the directory and bucket info, then scan the slots; a
//  remove that finds the key moves the last record into its slot. an insert
//  with a split first copies the old half when the directory doubles, then
//  repoints directory entries, redistributes the records, writes both bucket
//  infos and looks the key up again. each request returns to the idle state
//  before the next transfer in. after reset an init pass writes directory and bucket 0 and 1.
//  a finished result waits in the output register while out_ready_i is low.
// ----------------------------------------------------------------------------
module extendible_hash_table
  import ehash_pkg::*;
#(
  parameter int unsigned MAX_DEPTH   = 8,
  parameter int unsigned MAX_BUCKETS = 256,
  parameter int unsigned SLOTS       = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  req_t       in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output rsp_t       out_data_o,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i
);

  localparam int unsigned DIW = MAX_DEPTH;
  localparam int unsigned BW  = $clog2(MAX_BUCKETS);
  localparam int unsigned SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW  = $clog2(SLOTS + 1);
  localparam int unsigned LW  = $clog2(MAX_DEPTH + 1);
  localparam int unsigned BCW = $clog2(MAX_BUCKETS + 1);
  localparam int unsigned RAW = BW + SW;
  localparam int unsigned BIW = LW + CW;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_DIR, S_INFO, S_EVAL,
    S_GROW_RD, S_GROW_WR, S_SPLIT_RD, S_SPLIT_WR,
    S_DIST_RD, S_DIST_WR, S_FIX_B, S_FIX_N,
    S_SCAN_RD, S_SCAN_CMP, S_RM_RD, S_RM_WR, S_DONE
  } state_e;

  state_e        state_q;
  logic          init_q;
  logic [3:0]    cap_q;
  logic [LW-1:0] gd_q;
  logic [BCW-1:0] bcnt_q;
  req_t          req_q;
  logic [BW-1:0] b_q, nb_q;
  logic [LW-1:0] ld_q;
  logic [CW-1:0] cnt_q, i_q, s_q, cb_q, cn_q;
  logic [DIW:0]  j_q;
  rsp_t          res_q;
  rsp_t          out_q;
  logic          out_valid_q;

  // memory ports
  logic           dir_we;
  logic [DIW-1:0] dir_waddr, dir_raddr;
  logic [BW-1:0]  dir_wdata, dir_rdata;
  logic           bi_we;
  logic [BW-1:0]  bi_waddr;
  logic [BIW-1:0] bi_wdata, bi_rdata;
  logic           rec_we;
  logic [RAW-1:0] rec_waddr, rec_raddr;
  rec_t           rec_wdata, rec_rdata;

  ehash_ram #(.W(BW), .DEPTH(2 ** DIW)) u_dir (
    .clk_i, .we_i(dir_we), .waddr_i(dir_waddr), .wdata_i(dir_wdata),
    .raddr_i(dir_raddr), .rdata_o(dir_rdata)
  );

  ehash_ram #(.W(BIW), .DEPTH(2 ** BW)) u_info (
    .clk_i, .we_i(bi_we), .waddr_i(bi_waddr), .wdata_i(bi_wdata),
    .raddr_i(dir_rdata), .rdata_o(bi_rdata)
  );

  ehash_ram #(.W(REC_W), .DEPTH(2 ** RAW)) u_rec (
    .clk_i, .we_i(rec_we), .waddr_i(rec_waddr), .wdata_i(rec_wdata),
    .raddr_i(rec_raddr), .rdata_o(rec_rdata)
  );

  // derived values
  logic [LW-1:0]  ld_r;
  logic [CW-1:0]  cnt_r, eff_cap, cnt_m1;
  logic [DIW:0]   dsize;
  logic [DIW-1:0] key_idx, grow_addr;
  logic           grow;
  logic           route;
  logic [3:0]     len_n;
  logic [63:0]    val_n;

  assign ld_r      = bi_rdata[BIW-1:CW];
  assign cnt_r     = bi_rdata[CW-1:0];
  assign cnt_m1    = cnt_q - CW'(1);
  assign dsize     = (DIW + 1)'(1) << gd_q;
  assign key_idx   = req_q.key[DIW-1:0] & dsize[DIW-1:0] - DIW'(1) | (dsize[DIW] ?
                     req_q.key[DIW-1:0] : DIW'(0));
  assign grow_addr = j_q[DIW-1:0] + dsize[DIW-1:0];
  assign grow      = ld_r >= gd_q;
  assign route     = rec_rdata.key[ld_q];

  // effective capacity, clamped to 1..SLOTS
  always_comb begin
    if (cap_q == 4'd0) begin
      eff_cap = CW'(1);
    end else if (int'(cap_q) > int'(SLOTS)) begin
      eff_cap = CW'(SLOTS);
    end else begin
      eff_cap = CW'(cap_q);
    end
  end

  // insert length clamp and value byte mask
  always_comb begin
    len_n = in_data_i.value_length;
    if (len_n == 4'd0) len_n = 4'd1;
    if (len_n > 4'd8) len_n = 4'd8;
    for (int k = 0; k < 8; k++) begin
      val_n[8*k +: 8] = (4'(k) < len_n) ? in_data_i.value[8*k +: 8] : 8'd0;
    end
  end

  // memory address and write control
  always_comb begin
    dir_we    = 1'b0;
    dir_waddr = j_q[DIW-1:0];
    dir_wdata = nb_q;
    dir_raddr = key_idx;
    bi_we     = 1'b0;
    bi_waddr  = b_q;
    bi_wdata  = {ld_q, cnt_q};
    rec_we    = 1'b0;
    rec_waddr = {b_q, cnt_r[SW-1:0]};
    rec_wdata = '{key: req_q.key, value: req_q.value, len: req_q.value_length};
    rec_raddr = {b_q, i_q[SW-1:0]};
    unique case (state_q)
      S_INIT: begin
        dir_we    = 1'b1;
        dir_waddr = DIW'(init_q);
        dir_wdata = BW'(init_q);
        bi_we     = 1'b1;
        bi_waddr  = BW'(init_q);
        bi_wdata  = {LW'(1), CW'(0)};
      end
      S_EVAL: begin
        if (req_q.action == ACT_INSERT && cnt_r < eff_cap) begin
          rec_we   = 1'b1;
          bi_we    = 1'b1;
          bi_wdata = {ld_r, cnt_r + CW'(1)};
        end
      end
      S_GROW_RD, S_SPLIT_RD: dir_raddr = j_q[DIW-1:0];
      S_GROW_WR: begin
        dir_we    = 1'b1;
        dir_waddr = grow_addr;
        dir_wdata = dir_rdata;
      end
      S_SPLIT_WR: dir_we = (dir_rdata == b_q) && j_q[ld_q];
      S_DIST_WR: begin
        rec_we    = 1'b1;
        rec_wdata = rec_rdata;
        rec_waddr = route ? {nb_q, cn_q[SW-1:0]} : {b_q, cb_q[SW-1:0]};
      end
      S_FIX_B: begin
        bi_we    = 1'b1;
        bi_wdata = {ld_q + LW'(1), cb_q};
      end
      S_FIX_N: begin
        bi_we    = 1'b1;
        bi_waddr = nb_q;
        bi_wdata = {ld_q + LW'(1), cn_q};
      end
      S_RM_RD: rec_raddr = {b_q, cnt_m1[SW-1:0]};
      S_RM_WR: begin
        rec_we    = 1'b1;
        rec_wdata = rec_rdata;
        rec_waddr = {b_q, s_q[SW-1:0]};
        bi_we     = 1'b1;
        bi_wdata  = {ld_q, cnt_m1};
      end
      default: ;
    endcase
  end

  // sequencer, table state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      init_q      <= 1'b0;
      cap_q       <= 4'd8;
      gd_q        <= LW'(1);
      bcnt_q      <= BCW'(2);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      if (out_valid_q && out_ready_i && state_q != S_DONE) out_valid_q <= 1'b0;
      unique case (state_q)
        S_INIT: begin
          init_q <= 1'b1;
          if (init_q) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid_i) begin
            req_q.action       <= in_data_i.action;
            req_q.key          <= in_data_i.key;
            req_q.value        <= val_n;
            req_q.value_length <= len_n;
            res_q              <= '{status: ST_NOTFOUND, value_out: '0, length_out: '0};
            state_q            <= (in_data_i.action == ACT_UNUSED) ? S_DONE : S_DIR;
          end
        end
        S_DIR: state_q <= S_INFO;
        S_INFO: begin
          b_q     <= dir_rdata;
          state_q <= S_EVAL;
        end
        S_EVAL: begin
          ld_q  <= ld_r;
          cnt_q <= cnt_r;
          i_q   <= '0;
          j_q   <= '0;
          if (req_q.action != ACT_INSERT) begin
            state_q <= (cnt_r == '0) ? S_DONE : S_SCAN_RD;
          end else if (cnt_r < eff_cap) begin
            res_q.status <= ST_INSERTED;
            state_q      <= S_DONE;
          end else if ((grow && gd_q == LW'(MAX_DEPTH)) ||
                       bcnt_q == BCW'(MAX_BUCKETS)) begin
            res_q.status <= ST_FULL;
            state_q      <= S_DONE;
          end else begin
            nb_q    <= bcnt_q[BW-1:0];
            bcnt_q  <= bcnt_q + BCW'(1);
            state_q <= grow ? S_GROW_RD : S_SPLIT_RD;
          end
        end
        // directory doubling: upper half copies lower half
        S_GROW_RD: state_q <= S_GROW_WR;
        S_GROW_WR: begin
          if (j_q + (DIW + 1)'(1) == dsize) begin
            gd_q    <= gd_q + LW'(1);
            j_q     <= '0;
            state_q <= S_SPLIT_RD;
          end else begin
            j_q     <= j_q + (DIW + 1)'(1);
            state_q <= S_GROW_RD;
          end
        end
        // repoint old-bucket entries with the old-depth bit set to the new bucket
        S_SPLIT_RD: state_q <= S_SPLIT_WR;
        S_SPLIT_WR: begin
          j_q <= j_q + (DIW + 1)'(1);
          if (j_q + (DIW + 1)'(1) == dsize) begin
            cb_q    <= '0;
            cn_q    <= '0;
            state_q <= (cnt_q == '0) ? S_FIX_B : S_DIST_RD;
          end else begin
            state_q <= S_SPLIT_RD;
          end
        end
        // redistribute records in slot order, in place for the old bucket
        S_DIST_RD: state_q <= S_DIST_WR;
        S_DIST_WR: begin
          if (route) cn_q <= cn_q + CW'(1);
          else cb_q <= cb_q + CW'(1);
          i_q     <= i_q + CW'(1);
          state_q <= (i_q + CW'(1) == cnt_q) ? S_FIX_B : S_DIST_RD;
        end
        S_FIX_B: state_q <= S_FIX_N;
        S_FIX_N: state_q <= S_DIR;
        // bucket scan for search and remove
        S_SCAN_RD: state_q <= S_SCAN_CMP;
        S_SCAN_CMP: begin
          if (rec_rdata.key == req_q.key) begin
            res_q   <= '{status: ST_FOUND, value_out: rec_rdata.value,
                         length_out: rec_rdata.len};
            s_q     <= i_q;
            state_q <= (req_q.action == ACT_REMOVE) ? S_RM_RD : S_DONE;
          end else if (i_q + CW'(1) == cnt_q) begin
            state_q <= S_DONE;
          end else begin
            i_q     <= i_q + CW'(1);
            state_q <= S_SCAN_RD;
          end
        end
        S_RM_RD: state_q <= S_RM_WR;
        S_RM_WR: state_q <= S_DONE;
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a transfer in starts work, so the input closes next cycle
  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input still open after a transfer");

  a_depth_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gd_q >= LW'(1) && gd_q <= LW'(MAX_DEPTH))
    else $error("global depth out of range");

  a_bucket_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bcnt_q >= BCW'(2) && bcnt_q <= BCW'(MAX_BUCKETS))
    else $error("bucket count out of range");

endmodule
